// File: rtl/sst_pkg.sv
`default_nettype none

package sst_pkg;

	// stream limits and field widths
	localparam int MAX_SOURCE_BYTES = 65536;
	localparam int POS_W = $clog2(MAX_SOURCE_BYTES);
	localparam int KIND_W = 5;
	localparam int START_W = 16;
	localparam int LEN_W = 17;
	localparam int MAX_TOKENS = 3;
	localparam int CNT_W = $clog2(MAX_TOKENS + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SOURCE_BYTES - 1);

	// characters with a role in the scanner
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_EQ = 8'h3D;

	// token kinds
	localparam logic [KIND_W-1:0] K_MACRO = 5'd0;
	localparam logic [KIND_W-1:0] K_COMMA = 5'd1;
	localparam logic [KIND_W-1:0] K_SEMI = 5'd2;
	localparam logic [KIND_W-1:0] K_LPAREN = 5'd3;
	localparam logic [KIND_W-1:0] K_RPAREN = 5'd4;
	localparam logic [KIND_W-1:0] K_LBRACKET = 5'd5;
	localparam logic [KIND_W-1:0] K_RBRACKET = 5'd6;
	localparam logic [KIND_W-1:0] K_LBRACE = 5'd7;
	localparam logic [KIND_W-1:0] K_RBRACE = 5'd8;
	localparam logic [KIND_W-1:0] K_PLUS = 5'd9;
	localparam logic [KIND_W-1:0] K_MINUS = 5'd10;
	localparam logic [KIND_W-1:0] K_STAR = 5'd11;
	localparam logic [KIND_W-1:0] K_DIV = 5'd12;
	localparam logic [KIND_W-1:0] K_MOD = 5'd13;
	localparam logic [KIND_W-1:0] K_LT = 5'd14;
	localparam logic [KIND_W-1:0] K_LE = 5'd15;
	localparam logic [KIND_W-1:0] K_GT = 5'd16;
	localparam logic [KIND_W-1:0] K_GE = 5'd17;
	localparam logic [KIND_W-1:0] K_OR = 5'd18;
	localparam logic [KIND_W-1:0] K_LOR = 5'd19;
	localparam logic [KIND_W-1:0] K_AND = 5'd20;
	localparam logic [KIND_W-1:0] K_LAND = 5'd21;
	localparam logic [KIND_W-1:0] K_ASSIGN = 5'd22;
	localparam logic [KIND_W-1:0] K_EQUAL = 5'd23;
	localparam logic [KIND_W-1:0] K_QUESTION = 5'd24;
	localparam logic [KIND_W-1:0] K_COLON = 5'd25;
	localparam logic [KIND_W-1:0] K_DOT = 5'd26;
	localparam logic [KIND_W-1:0] K_LIT = 5'd27;
	localparam logic [KIND_W-1:0] K_IDENT = 5'd28;
	localparam logic [KIND_W-1:0] K_END = 5'd29;

	typedef enum logic [3:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_MACRO,
		MODE_IDENT,
		MODE_LIT,
		MODE_OP_LT,
		MODE_OP_GT,
		MODE_OP_OR,
		MODE_OP_AND,
		MODE_OP_EQ
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       final_byte;
	} sst_in_t;

	typedef struct packed {
		logic [KIND_W-1:0]  token_kind;
		logic [START_W-1:0] start_pos;
		logic [LEN_W-1:0]   token_len;
		logic               run_last;
	} sst_out_t;

	typedef struct packed {
		scan_mode_t       mode;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] start;
	} sst_state_t;

	typedef struct packed {
		sst_out_t [MAX_TOKENS-1:0] tok;
		logic [CNT_W-1:0]          count;
	} sst_group_t;

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} kind_hit_t;

	typedef struct packed {
		logic       hit;
		scan_mode_t mode;
	} mode_hit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	// one-byte punctuation
	function automatic kind_hit_t single_kind(input logic [7:0] c);
		kind_hit_t r;
		r.hit = 1'b1;
		r.kind = K_COMMA;
		unique case (c)
			",": r.kind = K_COMMA;
			";": r.kind = K_SEMI;
			"(": r.kind = K_LPAREN;
			")": r.kind = K_RPAREN;
			"[": r.kind = K_LBRACKET;
			"]": r.kind = K_RBRACKET;
			"{": r.kind = K_LBRACE;
			"}": r.kind = K_RBRACE;
			"+": r.kind = K_PLUS;
			"-": r.kind = K_MINUS;
			"*": r.kind = K_STAR;
			"%": r.kind = K_MOD;
			"?": r.kind = K_QUESTION;
			":": r.kind = K_COLON;
			".": r.kind = K_DOT;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// bytes that may start a two-byte operator
	function automatic mode_hit_t op_mode(input logic [7:0] c);
		mode_hit_t r;
		r.hit = 1'b1;
		r.mode = MODE_NORMAL;
		unique case (c)
			CH_LT:  r.mode = MODE_OP_LT;
			CH_GT:  r.mode = MODE_OP_GT;
			CH_BAR: r.mode = MODE_OP_OR;
			CH_AMP: r.mode = MODE_OP_AND;
			CH_EQ:  r.mode = MODE_OP_EQ;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] op_second(input scan_mode_t m);
		logic [7:0] r;
		unique case (m)
			MODE_OP_OR:  r = CH_BAR;
			MODE_OP_AND: r = CH_AMP;
			default:     r = CH_EQ;
		endcase
		return r;
	endfunction

	function automatic logic [KIND_W-1:0] op_single(input scan_mode_t m);
		logic [KIND_W-1:0] r;
		unique case (m)
			MODE_OP_LT:  r = K_LT;
			MODE_OP_GT:  r = K_GT;
			MODE_OP_OR:  r = K_OR;
			MODE_OP_AND: r = K_AND;
			default:     r = K_ASSIGN;
		endcase
		return r;
	endfunction

	function automatic logic [KIND_W-1:0] op_double(input scan_mode_t m);
		logic [KIND_W-1:0] r;
		unique case (m)
			MODE_OP_LT:  r = K_LE;
			MODE_OP_GT:  r = K_GE;
			MODE_OP_OR:  r = K_LOR;
			MODE_OP_AND: r = K_LAND;
			default:     r = K_EQUAL;
		endcase
		return r;
	endfunction

	function automatic logic is_op_mode(input scan_mode_t m);
		return (m == MODE_OP_LT) || (m == MODE_OP_GT) || (m == MODE_OP_OR) ||
			(m == MODE_OP_AND) || (m == MODE_OP_EQ);
	endfunction

	function automatic sst_out_t mk_tok(input logic [KIND_W-1:0] kind,
			input logic [START_W-1:0] start, input logic [LEN_W-1:0] len);
		sst_out_t t;
		t.token_kind = kind;
		t.start_pos = start;
		t.token_len = len;
		t.run_last = 1'b0;
		return t;
	endfunction

endpackage

`default_nettype wire

// File: rtl/shader_source_tokenizer.sv
`default_nettype none

// channel  dir  handshake             payload
// src      in   src_valid/src_stall   sst_in_t  (char_code, final_byte)
// tok      out  tok_valid/tok_stall   sst_out_t (token_kind, start_pos, token_len, run_last)
//
// A byte is scanned from the input register into a result buffer of up to three
// tokens; unless the output stalls, tokens leave one per cycle from its head.
// Bytes giving at most one token sustain one byte per cycle while the output is not
// stalled; a byte giving more holds the input as they leave the single output port.
// Reset clears the scan mode, byte offset and token start, and empties both stages.
// A stalled output holds the head token; the input stalls only while its register
// is full and the result buffer cannot be refilled in that cycle.

module shader_source_tokenizer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  src_valid,
	output logic                 src_stall,
	input  sst_pkg::sst_in_t     src,
	output logic                 tok_valid,
	input  wire                  tok_stall,
	output sst_pkg::sst_out_t    tok
);

	sst_pkg::sst_in_t                            src_s1;
	logic                                        src_valid_s1;
	sst_pkg::sst_state_t                         st_q;
	sst_pkg::sst_state_t                         st_next;
	sst_pkg::sst_group_t                         grp;
	sst_pkg::sst_out_t [sst_pkg::MAX_TOKENS-1:0] res_q;
	logic [sst_pkg::CNT_W-1:0]                   res_cnt_q;
	logic                                        drain;
	logic                                        load;
	logic                                        accept;
	logic                                        pop;

	// handshake
	assign pop = tok_valid && !tok_stall;
	assign drain = (res_cnt_q == '0) ||
		((res_cnt_q == sst_pkg::CNT_W'(1)) && !tok_stall);
	assign load = src_valid_s1 && drain;
	assign src_stall = src_valid_s1 && !drain;
	assign accept = src_valid && !src_stall;
	assign tok_valid = (res_cnt_q != '0);
	assign tok = res_q[0];

	sst_scan u_scan (
		.st      (st_q),
		.src     (src_s1),
		.st_next (st_next),
		.grp     (grp)
	);

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) src_s1 <= src;
	end

	// input register valid and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid_s1 <= 1'b0;
			st_q.mode <= sst_pkg::MODE_NORMAL;
			st_q.pos <= '0;
			st_q.start <= '0;
		end else begin
			if (accept) src_valid_s1 <= 1'b1;
			else if (load) src_valid_s1 <= 1'b0;
			if (load) st_q <= st_next;
		end
	end

	// result buffer payload: refill or shift toward the head
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.tok;
		end else if (pop) begin
			for (int i = 0; i < sst_pkg::MAX_TOKENS - 1; i++) res_q[i] <= res_q[i+1];
		end
	end

	// result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else begin
			if (load) res_cnt_q <= grp.count;
			else if (pop) res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	// a token that is not the last of its byte is always followed by another
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !tok.run_last) |=> tok_valid)
		else $error("token group cut short");

	// the end token closes its group and has no length
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (tok.token_kind == sst_pkg::K_END)) |->
			(tok.run_last && (tok.token_len == '0)))
		else $error("malformed end token");

	// the final byte restarts the offset count
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(load && src_s1.final_byte) |=>
			((st_q.pos == '0) && (st_q.mode == sst_pkg::MODE_NORMAL)))
		else $error("state not cleared after final byte");

	// input stalls only behind a full input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (src_valid_s1 && tok_valid))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

// File: rtl/sst_scan.sv
`default_nettype none

module sst_scan (
	input  sst_pkg::sst_state_t st,
	input  sst_pkg::sst_in_t    src,
	output sst_pkg::sst_state_t st_next,
	output sst_pkg::sst_group_t grp
);

	logic [7:0]                  c;
	logic                        blank;
	logic                        ident_char;
	logic                        lit_char;
	sst_pkg::kind_hit_t          single;
	sst_pkg::mode_hit_t          opm;
	logic                        rescan;
	sst_pkg::scan_mode_t         mode_mid;
	logic [sst_pkg::POS_W-1:0]   start_mid;
	logic [sst_pkg::LEN_W-1:0]   pos_x;
	logic [sst_pkg::LEN_W-1:0]   start_x;
	logic [sst_pkg::LEN_W-1:0]   start_mid_x;
	logic [sst_pkg::START_W-1:0] cur_start;
	logic [sst_pkg::START_W-1:0] mid_start;
	logic [sst_pkg::CNT_W-1:0]   n;

	// byte classes
	always_comb begin
		c = src.char_code;
		blank = (c == sst_pkg::CH_SPACE) || (c == sst_pkg::CH_TAB) ||
			(c == sst_pkg::CH_CR) || (c == sst_pkg::CH_LF);
		ident_char = sst_pkg::is_alpha(c) || sst_pkg::is_digit(c) ||
			(c == sst_pkg::CH_UNDERSCORE) || (c == sst_pkg::CH_DOT);
		lit_char = sst_pkg::is_digit(c) || (c == sst_pkg::CH_DOT);
		single = sst_pkg::single_kind(c);
		opm = sst_pkg::op_mode(c);
	end

	// next mode: finish the open token, then rescan the byte if it ended one
	always_comb begin
		rescan = 1'b0;
		mode_mid = st.mode;
		start_mid = st.start;
		unique case (st.mode)
			sst_pkg::MODE_SLASH: begin
				if (c == sst_pkg::CH_SLASH) mode_mid = sst_pkg::MODE_COMMENT;
				else rescan = 1'b1;
			end
			sst_pkg::MODE_COMMENT, sst_pkg::MODE_MACRO: begin
				if (c == sst_pkg::CH_LF) mode_mid = sst_pkg::MODE_NORMAL;
			end
			sst_pkg::MODE_IDENT: begin
				if (!ident_char) rescan = 1'b1;
			end
			sst_pkg::MODE_LIT: begin
				if (c == sst_pkg::CH_F) mode_mid = sst_pkg::MODE_NORMAL;
				else if (!lit_char) rescan = 1'b1;
			end
			sst_pkg::MODE_OP_LT, sst_pkg::MODE_OP_GT, sst_pkg::MODE_OP_OR,
			sst_pkg::MODE_OP_AND, sst_pkg::MODE_OP_EQ: begin
				if (c == sst_pkg::op_second(st.mode)) mode_mid = sst_pkg::MODE_NORMAL;
				else rescan = 1'b1;
			end
			default: rescan = 1'b1;
		endcase

		if (rescan) begin
			mode_mid = sst_pkg::MODE_NORMAL;
			if (!blank) begin
				start_mid = st.pos;
				priority if (c == sst_pkg::CH_SLASH) mode_mid = sst_pkg::MODE_SLASH;
				else if (c == sst_pkg::CH_HASH) mode_mid = sst_pkg::MODE_MACRO;
				else if (single.hit) mode_mid = sst_pkg::MODE_NORMAL;
				else if (opm.hit) mode_mid = opm.mode;
				else if (sst_pkg::is_digit(c)) mode_mid = sst_pkg::MODE_LIT;
				else if (sst_pkg::is_alpha(c) || (c == sst_pkg::CH_UNDERSCORE))
					mode_mid = sst_pkg::MODE_IDENT;
				else mode_mid = sst_pkg::MODE_NORMAL;
			end
		end

		// final byte returns the scanner to its reset state
		if (src.final_byte) begin
			st_next.mode = sst_pkg::MODE_NORMAL;
			st_next.pos = '0;
			st_next.start = '0;
		end else begin
			st_next.mode = mode_mid;
			st_next.start = start_mid;
			st_next.pos = (st.pos < sst_pkg::POS_LIMIT) ? st.pos + 1'b1 : st.pos;
		end
	end

	// token records, packed in emit order
	always_comb begin
		pos_x = sst_pkg::LEN_W'(st.pos);
		start_x = sst_pkg::LEN_W'(st.start);
		start_mid_x = sst_pkg::LEN_W'(start_mid);
		cur_start = sst_pkg::START_W'(st.start);
		mid_start = sst_pkg::START_W'(start_mid);
		grp = '0;
		n = '0;

		// token closed by this byte
		unique case (st.mode)
			sst_pkg::MODE_SLASH: begin
				if (c != sst_pkg::CH_SLASH) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_DIV, cur_start,
						sst_pkg::LEN_W'(1));
					n = n + 1'b1;
				end
			end
			sst_pkg::MODE_MACRO: begin
				if (c == sst_pkg::CH_LF) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_MACRO, cur_start,
						pos_x - start_x);
					n = n + 1'b1;
				end
			end
			sst_pkg::MODE_IDENT: begin
				if (!ident_char) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_IDENT, cur_start,
						pos_x - start_x);
					n = n + 1'b1;
				end
			end
			sst_pkg::MODE_LIT: begin
				if (c == sst_pkg::CH_F) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_LIT, cur_start,
						pos_x + 1'b1 - start_x);
					n = n + 1'b1;
				end else if (!lit_char) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_LIT, cur_start,
						pos_x - start_x);
					n = n + 1'b1;
				end
			end
			sst_pkg::MODE_OP_LT, sst_pkg::MODE_OP_GT, sst_pkg::MODE_OP_OR,
			sst_pkg::MODE_OP_AND, sst_pkg::MODE_OP_EQ: begin
				if (c == sst_pkg::op_second(st.mode)) begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::op_double(st.mode), cur_start,
						sst_pkg::LEN_W'(2));
				end else begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::op_single(st.mode), cur_start,
						sst_pkg::LEN_W'(1));
				end
				n = n + 1'b1;
			end
			default: ;
		endcase

		// punctuation found on rescan
		if (rescan && single.hit) begin
			grp.tok[n] = sst_pkg::mk_tok(single.kind, sst_pkg::START_W'(st.pos),
				sst_pkg::LEN_W'(1));
			n = n + 1'b1;
		end

		// end of stream: close what is open, then the end marker
		if (src.final_byte) begin
			unique case (mode_mid)
				sst_pkg::MODE_SLASH: begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_DIV, mid_start,
						sst_pkg::LEN_W'(1));
					n = n + 1'b1;
				end
				sst_pkg::MODE_MACRO: begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_MACRO, mid_start,
						pos_x + 1'b1 - start_mid_x);
					n = n + 1'b1;
				end
				sst_pkg::MODE_IDENT: begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_IDENT, mid_start,
						pos_x + 1'b1 - start_mid_x);
					n = n + 1'b1;
				end
				sst_pkg::MODE_LIT: begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_LIT, mid_start,
						pos_x + 1'b1 - start_mid_x);
					n = n + 1'b1;
				end
				sst_pkg::MODE_OP_LT, sst_pkg::MODE_OP_GT, sst_pkg::MODE_OP_OR,
				sst_pkg::MODE_OP_AND, sst_pkg::MODE_OP_EQ: begin
					grp.tok[n] = sst_pkg::mk_tok(sst_pkg::op_single(mode_mid), mid_start,
						sst_pkg::LEN_W'(1));
					n = n + 1'b1;
				end
				default: ;
			endcase
			grp.tok[n] = sst_pkg::mk_tok(sst_pkg::K_END,
				sst_pkg::START_W'(pos_x + 1'b1), '0);
			n = n + 1'b1;
		end

		if (n != '0) grp.tok[n - 1'b1].run_last = 1'b1;
		grp.count = n;
	end

endmodule

`default_nettype wire

// File: bench/shader_source_tokenizer_tb.sv
module shader_source_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int ROW_PREDICT = -1;
	localparam int DRILL_ROWS = 25;
	localparam int RANDOM_BYTES = 310;
	localparam int DRAIN_CYCLES = 16;
	localparam sst_out_t NO_TOK = '0;

	// one directed byte, with its tokens typed in when n is not ROW_PREDICT
	typedef struct {
		logic [7:0] ch;
		logic       fin;
		int         n;
		sst_out_t   t0;
		sst_out_t   t1;
		sst_out_t   t2;
	} drill_t;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	sst_in_t  src = '0;
	logic     tok_valid;
	logic     tok_stall = 1'b0;
	sst_out_t tok;

	// tokenizer shadow state
	scan_mode_t  scan_st;
	int unsigned cur_pos;
	int unsigned tok_origin;
	sst_out_t    step_tokens[$];

	sst_out_t expected_tokens[$];
	sst_out_t want;
	drill_t   drills [DRILL_ROWS];
	int       n_drills = 0;
	int       fail_count = 0;

	shader_source_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src(src),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok(tok)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic sst_out_t tk(input logic [KIND_W-1:0] kind, input int start,
			input int len, input logic last);
		sst_out_t t;
		t.token_kind = kind;
		t.start_pos = start[START_W-1:0];
		t.token_len = len[LEN_W-1:0];
		t.run_last = last;
		return t;
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic int punct_kind(input logic [7:0] c);
		case (c)
			",": return K_COMMA;
			";": return K_SEMI;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"[": return K_LBRACKET;
			"]": return K_RBRACKET;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"%": return K_MOD;
			"?": return K_QUESTION;
			":": return K_COLON;
			".": return K_DOT;
			default: return -1;
		endcase
	endfunction

	// lookahead operators: the mode a byte opens, and what that mode can become
	function automatic logic op_open(input logic [7:0] c, output scan_mode_t m);
		m = MODE_NORMAL;
		case (c)
			CH_LT: m = MODE_OP_LT;
			CH_GT: m = MODE_OP_GT;
			CH_BAR: m = MODE_OP_OR;
			CH_AMP: m = MODE_OP_AND;
			CH_EQ: m = MODE_OP_EQ;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void op_codes(input scan_mode_t m, output logic [7:0] second,
			output logic [KIND_W-1:0] one, output logic [KIND_W-1:0] two);
		case (m)
			MODE_OP_LT: begin
				second = CH_EQ; one = K_LT; two = K_LE;
			end
			MODE_OP_GT: begin
				second = CH_EQ; one = K_GT; two = K_GE;
			end
			MODE_OP_OR: begin
				second = CH_BAR; one = K_OR; two = K_LOR;
			end
			MODE_OP_AND: begin
				second = CH_AMP; one = K_AND; two = K_LAND;
			end
			default: begin
				second = CH_EQ; one = K_ASSIGN; two = K_EQUAL;
			end
		endcase
	endfunction

	// append one token to the scoreboard
	function automatic void queue_expected(input sst_out_t t);
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	// at most three tokens per byte, fields cut to port widths
	function automatic void add_token(input logic [KIND_W-1:0] kind, input int unsigned start,
			input int unsigned len);
		sst_out_t t;
		if (step_tokens.size() >= MAX_TOKENS)
			return;
		t.token_kind = kind;
		t.start_pos = start[START_W-1:0];
		t.token_len = len[LEN_W-1:0];
		t.run_last = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	// a byte seen in normal mode
	function automatic void begin_token(input logic [7:0] c, input int unsigned pos);
		int k;
		scan_mode_t om;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
			return;
		tok_origin = pos;
		k = punct_kind(c);
		if (c == CH_SLASH)
			scan_st = MODE_SLASH;
		else if (c == CH_HASH)
			scan_st = MODE_MACRO;
		else if (k >= 0)
			add_token(k[KIND_W-1:0], pos, 1);
		else if (op_open(c, om))
			scan_st = om;
		else if (digit_char(c))
			scan_st = MODE_LIT;
		else if (letter_char(c) || c == CH_UNDERSCORE)
			scan_st = MODE_IDENT;
	endfunction

	// tokens caused by one byte, left in step_tokens
	function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
		int unsigned pos;
		logic [7:0] second;
		logic [KIND_W-1:0] one;
		logic [KIND_W-1:0] two;
		step_tokens.delete();
		pos = cur_pos;
		case (scan_st)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					scan_st = MODE_COMMENT;
				end else begin
					add_token(K_DIV, tok_origin, 1);
					scan_st = MODE_NORMAL;
					begin_token(c, pos);
				end
			end
			MODE_COMMENT: begin
				if (c == CH_LF)
					scan_st = MODE_NORMAL;
			end
			MODE_MACRO: begin
				if (c == CH_LF) begin
					add_token(K_MACRO, tok_origin, pos - tok_origin);
					scan_st = MODE_NORMAL;
				end
			end
			MODE_IDENT: begin
				if (!(letter_char(c) || digit_char(c) || c == CH_UNDERSCORE || c == CH_DOT)) begin
					add_token(K_IDENT, tok_origin, pos - tok_origin);
					scan_st = MODE_NORMAL;
					begin_token(c, pos);
				end
			end
			MODE_LIT: begin
				if (c == CH_F) begin
					add_token(K_LIT, tok_origin, pos + 1 - tok_origin);
					scan_st = MODE_NORMAL;
				end else if (!(digit_char(c) || c == CH_DOT)) begin
					add_token(K_LIT, tok_origin, pos - tok_origin);
					scan_st = MODE_NORMAL;
					begin_token(c, pos);
				end
			end
			MODE_OP_LT, MODE_OP_GT, MODE_OP_OR, MODE_OP_AND, MODE_OP_EQ: begin
				op_codes(scan_st, second, one, two);
				scan_st = MODE_NORMAL;
				if (c == second) begin
					add_token(two, tok_origin, 2);
				end else begin
					add_token(one, tok_origin, 1);
					begin_token(c, pos);
				end
			end
			default: begin
				scan_st = MODE_NORMAL;
				begin_token(c, pos);
			end
		endcase

		// last byte closes what is open, adds the end token and restarts at offset 0
		if (fin) begin
			case (scan_st)
				MODE_SLASH: add_token(K_DIV, tok_origin, 1);
				MODE_MACRO: add_token(K_MACRO, tok_origin, pos + 1 - tok_origin);
				MODE_IDENT: add_token(K_IDENT, tok_origin, pos + 1 - tok_origin);
				MODE_LIT: add_token(K_LIT, tok_origin, pos + 1 - tok_origin);
				MODE_OP_LT, MODE_OP_GT, MODE_OP_OR, MODE_OP_AND, MODE_OP_EQ: begin
					op_codes(scan_st, second, one, two);
					add_token(one, tok_origin, 1);
				end
				default: ;
			endcase
			add_token(K_END, pos + 1, 0);
			scan_st = MODE_NORMAL;
			cur_pos = 0;
			tok_origin = 0;
		end else if (cur_pos < POS_LIMIT) begin
			cur_pos++;
		end

		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].run_last = 1'b1;
	endfunction

	// random byte, weighted toward shader-like text
	function automatic logic [7:0] pick_char();
		int r;
		string punct;
		string ops;
		string blanks;
		punct = ",;()[]{}+-*%?:.";
		ops = "<>|&=";
		blanks = " \t\r\n";
		r = $urandom_range(0, 99);
		if (r < 20)
			return 8'("a" + $urandom_range(0, 25));
		if (r < 24)
			return 8'("A" + $urandom_range(0, 25));
		if (r < 26)
			return CH_UNDERSCORE;
		if (r < 38)
			return 8'("0" + $urandom_range(0, 9));
		if (r < 42)
			return CH_DOT;
		if (r < 45)
			return CH_F;
		if (r < 56)
			return blanks[$urandom_range(0, 3)];
		if (r < 70)
			return punct[$urandom_range(0, 14)];
		if (r < 82)
			return ops[$urandom_range(0, 4)];
		if (r < 87)
			return CH_SLASH;
		if (r < 90)
			return CH_HASH;
		if (r < 94)
			return CH_LF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_row(input logic [7:0] ch, input logic fin, input int n,
			input sst_out_t t0, input sst_out_t t1, input sst_out_t t2);
		drills[n_drills].ch = ch;
		drills[n_drills].fin = fin;
		drills[n_drills].n = n;
		drills[n_drills].t0 = t0;
		drills[n_drills].t1 = t1;
		drills[n_drills].t2 = t2;
		n_drills++;
	endtask

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			src <= sst_in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src <= '{char_code: c, final_byte: fin};
		do @(negedge clk); while (src_stall);
		@(posedge clk);
	endtask

	task automatic feed(input logic [7:0] c, input logic fin);
		send_byte(c, fin);
		tokenize_byte(c, fin);
		foreach (step_tokens[i])
			queue_expected(step_tokens[i]);
	endtask

	// receiver stall: stretches of flow, then stalls of random length
	initial begin : out_pacing
		int run;
		int hold;
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			hold = pick_gap();
			repeat (run) begin
				@(posedge clk);
				tok_stall <= 1'b0;
			end
			repeat (hold) begin
				@(posedge clk);
				tok_stall <= 1'b1;
			end
		end
	end

	// output transfer check, sampled mid-cycle where everything is settled
	always @(negedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("token with no expectation: kind %0d start %0d len %0d",
					tok.token_kind, tok.start_pos, tok.token_len);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (tok.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d, actual %0d", want.token_kind, tok.token_kind);
					fail_count++;
				end
				if (tok.start_pos !== want.start_pos) begin
					$error("start_pos: expected %0d, actual %0d", want.start_pos, tok.start_pos);
					fail_count++;
				end
				if (tok.token_len !== want.token_len) begin
					$error("token_len: expected %0d, actual %0d", want.token_len, tok.token_len);
					fail_count++;
				end
				if (tok.run_last !== want.run_last) begin
					$error("run_last: expected %0d, actual %0d", want.run_last, tok.run_last);
					fail_count++;
				end
			end
		end
	end

	initial begin : main
		int sent;
		int len;

		scan_st = MODE_NORMAL;
		cur_pos = 0;
		tok_origin = 0;

		// directed bytes
		add_row(",", 1'b0, 1, tk(K_COMMA, 0, 1, 1'b1), NO_TOK, NO_TOK);
		add_row(8'h00, 1'b0, 0, NO_TOK, NO_TOK, NO_TOK);
		add_row(8'hFF, 1'b0, 0, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_LT, 1'b0, 0, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_EQ, 1'b0, 1, tk(K_LE, 3, 2, 1'b1), NO_TOK, NO_TOK);
		// slash as the last byte is division
		add_row(CH_SLASH, 1'b1, 2, tk(K_DIV, 5, 1, 1'b0), tk(K_END, 6, 0, 1'b1), NO_TOK);
		// lone operator as the last byte, new stream back at offset 0
		add_row(CH_AMP, 1'b1, 2, tk(K_AND, 0, 1, 1'b0), tk(K_END, 1, 0, 1'b1), NO_TOK);
		// comment open at the end gives only the end token
		add_row(CH_SLASH, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_SLASH, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row("z", 1'b1, 1, tk(K_END, 3, 0, 1'b1), NO_TOK, NO_TOK);
		// macro open at the end includes the last byte
		add_row(CH_HASH, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row("d", 1'b1, 2, tk(K_MACRO, 0, 2, 1'b0), tk(K_END, 2, 0, 1'b1), NO_TOK);
		// identifier with digit and dot, open at the end
		add_row(CH_UNDERSCORE, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row("9", 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_DOT, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row("q", 1'b1, 2, tk(K_IDENT, 0, 4, 1'b0), tk(K_END, 4, 0, 1'b1), NO_TOK);
		// literal with float suffix, then a literal open at the end
		add_row("7", 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_DOT, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_F, 1'b0, 1, tk(K_LIT, 0, 3, 1'b1), NO_TOK, NO_TOK);
		add_row("3", 1'b1, 2, tk(K_LIT, 3, 1, 1'b0), tk(K_END, 4, 0, 1'b1), NO_TOK);
		// three tokens from one byte
		add_row("a", 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_BAR, 1'b0, 1, tk(K_IDENT, 0, 1, 1'b1), NO_TOK, NO_TOK);
		add_row(CH_GT, 1'b1, 3, tk(K_OR, 1, 1, 1'b0), tk(K_GT, 2, 1, 1'b0),
			tk(K_END, 3, 0, 1'b1));
		add_row(CH_TAB, 1'b0, ROW_PREDICT, NO_TOK, NO_TOK, NO_TOK);
		add_row(CH_CR, 1'b1, 1, tk(K_END, 2, 0, 1'b1), NO_TOK, NO_TOK);

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < n_drills; i++) begin
			send_byte(drills[i].ch, drills[i].fin);
			tokenize_byte(drills[i].ch, drills[i].fin);
			if (drills[i].n == ROW_PREDICT) begin
				foreach (step_tokens[j])
					queue_expected(step_tokens[j]);
			end else begin
				if (drills[i].n > 0)
					queue_expected(drills[i].t0);
				if (drills[i].n > 1)
					queue_expected(drills[i].t1);
				if (drills[i].n > 2)
					queue_expected(drills[i].t2);
			end
		end

		// random streams, each closed by a last byte
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
			for (int j = 0; j < len; j++) begin
				feed(pick_char(), j == len - 1);
				sent++;
			end
		end
		src_valid <= 1'b0;

		// drain
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
